// ===== rtl/pid_speed_pwm_controller_core_assert.svh =====
// ----------------------------------------------------------------------------
// PID speed controller assertion macros
// Shared property shapes for the controller's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PID_SPEED_PWM_CONTROLLER_CORE_ASSERT_SVH
`define PID_SPEED_PWM_CONTROLLER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// PID speed controller package
// Widths, register codes and payload types shared by the controller files.
// ----------------------------------------------------------------------------
package psc_pkg;

	localparam int SPEED_W    = 16;
	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 32;
	localparam int ERR_W      = 17;
	localparam int DIFF_W     = 18;
	localparam int TP_W       = 33;
	localparam int TI_W       = 32;
	localparam int TD_W       = 34;
	localparam int ACC_W      = 34;
	localparam int SUM_W      = 36;
	localparam int FRAC_W     = 8;
	localparam int WHOLE_W    = SUM_W - 1 - FRAC_W;
	localparam int DRIVE_W    = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [DRIVE_W-1:0] DRIVE_MAX = 10'd1023;
	localparam logic [DRIVE_W-1:0] DRIVE_MIN = 10'd120;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET      = 3'd0,
		REG_GAIN_P      = 3'd1,
		REG_GAIN_I      = 3'd2,
		REG_GAIN_D      = 3'd3,
		REG_INTEG_UPPER = 3'd4,
		REG_INTEG_LOWER = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] measured_speed;
		logic                      measured_valid;
	} meas_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] pwm_drive;
	} drive_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] target_speed;
		logic signed [GAIN_W-1:0]  gain_p;
		logic signed [GAIN_W-1:0]  gain_i;
		logic signed [GAIN_W-1:0]  gain_d;
		logic signed [LIMIT_W-1:0] integ_upper;
		logic signed [LIMIT_W-1:0] integ_lower;
	} cfg_t;

	typedef struct packed {
		logic signed [TP_W-1:0] term_p;
		logic signed [TI_W-1:0] term_i;
		logic signed [TD_W-1:0] term_d;
	} terms_t;

endpackage

// ===== rtl/psc_stream_if.sv =====
// ----------------------------------------------------------------------------
// PID speed controller stream interface
// Valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface psc_stream_if #(parameter type payload_t = logic) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/psc_terms.sv =====
// ----------------------------------------------------------------------------
// PID term stage
// Registers the sample, then forms the error, P, clamped I and D terms.
// ----------------------------------------------------------------------------
module psc_terms (
	input  logic            clk,
	input  logic            arst_n,
	input  psc_pkg::cfg_t   cfg,
	input  logic            adv,
	input  logic            take,
	input  psc_pkg::meas_t  meas_data,
	output logic            valid_s2,
	output psc_pkg::terms_t terms
);
	import psc_pkg::*;

	logic                     valid_s1;
	meas_t                    meas_s1;
	logic signed [ERR_W-1:0]  prev_error_q;
	logic signed [TP_W-1:0]   term_p_q;
	logic signed [TI_W-1:0]   integ_acc_q;
	logic signed [TD_W-1:0]   term_d_q;

	logic signed [ERR_W-1:0]  err;
	logic signed [DIFF_W-1:0] err_diff;
	logic signed [TP_W-1:0]   prod_p;
	logic signed [TP_W-1:0]   prod_i;
	logic signed [TD_W-1:0]   prod_d;
	logic signed [ACC_W-1:0]  integ_sum;
	logic signed [ACC_W-1:0]  integ_hi;
	logic signed [ACC_W-1:0]  integ_lo;
	logic signed [ACC_W-1:0]  integ_clamped;
	logic                     update;

	always_comb begin
		err      = ERR_W'(cfg.target_speed) - ERR_W'(meas_s1.measured_speed);
		err_diff = DIFF_W'(prev_error_q) - DIFF_W'(err);
		prod_p   = TP_W'(cfg.gain_p) * TP_W'(err);
		prod_i   = TP_W'(cfg.gain_i) * TP_W'(err);
		prod_d   = TD_W'(cfg.gain_d) * TD_W'(err_diff);
		integ_sum = ACC_W'(integ_acc_q) + ACC_W'(prod_i);
		integ_hi  = ACC_W'(cfg.integ_upper);
		integ_lo  = ACC_W'(cfg.integ_lower);
		// Upper limit first, then lower, so a crossed pair resolves to the lower limit.
		integ_clamped = integ_sum;
		if (integ_clamped > integ_hi) begin
			integ_clamped = integ_hi;
		end
		if (integ_clamped < integ_lo) begin
			integ_clamped = integ_lo;
		end
	end

	assign update = adv && valid_s1 && meas_s1.measured_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meas_s1 <= meas_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			term_p_q     <= '0;
			integ_acc_q  <= '0;
			term_d_q     <= '0;
		end else if (update) begin
			prev_error_q <= err;
			term_p_q     <= prod_p;
			integ_acc_q  <= TI_W'(integ_clamped);
			term_d_q     <= prod_d;
		end
	end

	// The integral term always equals the clamped integrator.
	assign terms.term_p = term_p_q;
	assign terms.term_i = integ_acc_q;
	assign terms.term_d = term_d_q;

endmodule

// ===== rtl/psc_drive.sv =====
// ----------------------------------------------------------------------------
// PID drive stage
// Sums the previous drive with the terms, truncates, clamps and outputs.
// ----------------------------------------------------------------------------
`include "pid_speed_pwm_controller_core_assert.svh"

module psc_drive (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s2,
	input  psc_pkg::terms_t terms,
	output logic            adv,
	psc_stream_if.source    drive
);
	import psc_pkg::*;

	logic [DRIVE_W-1:0]      prev_drive_q;
	logic [DRIVE_W-1:0]      out_q;
	logic                    out_valid_q;
	logic signed [SUM_W-1:0] total;
	logic [WHOLE_W-1:0]      whole;
	logic [DRIVE_W-1:0]      drive_next;

	// The pipeline moves whenever the result register is empty or being taken.
	assign adv = !out_valid_q || drive.ready;

	always_comb begin
		total = SUM_W'($signed({1'b0, prev_drive_q, FRAC_W'(0)}))
			+ SUM_W'(terms.term_p) + SUM_W'(terms.term_i) + SUM_W'(terms.term_d);
		whole = total[SUM_W-2:FRAC_W];
		// A negative sum truncates to zero or below and lands on the floor anyway,
		// so only non-negative sums need the shift, where floor equals truncation.
		if (total[SUM_W-1]) begin
			drive_next = DRIVE_MIN;
		end else if (whole > WHOLE_W'(DRIVE_MAX)) begin
			drive_next = DRIVE_MAX;
		end else if (whole < WHOLE_W'(DRIVE_MIN)) begin
			drive_next = DRIVE_MIN;
		end else begin
			drive_next = whole[DRIVE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			prev_drive_q <= '0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
			if (valid_s2) begin
				prev_drive_q <= drive_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			out_q <= drive_next;
		end
	end

	assign drive.valid             = out_valid_q;
	assign drive.payload.pwm_drive = out_q;

	`PSC_ASSERT_IMPL(a_drive_in_range, out_valid_q, (out_q >= DRIVE_MIN) && (out_q <= DRIVE_MAX), "pwm drive outside its clamp range")
	`PSC_ASSERT_IMPL(a_prev_tracks_out, out_valid_q, prev_drive_q == out_q, "stored drive differs from the pending result")
	`PSC_ASSERT_NEXT(a_item_reaches_out, adv && valid_s2, out_valid_q && (prev_drive_q == out_q), "advanced item did not reach the result register")

endmodule

// ===== rtl/pid_speed_pwm_controller_core.sv =====
// ----------------------------------------------------------------------------
// PID speed controller with PWM drive output
// Top level: configuration registers, term stage and drive stage.
// ----------------------------------------------------------------------------
// Usage:
// Speed samples arrive as requests on the meas channel (speed plus a flag that
// marks the sample usable); each request yields exactly one request on the
// drive channel carrying the new PWM drive value in 120..1023.
// From acceptance to the drive value being offered, the sample register holds
// the sample, the P, I and D term registers are updated from it, and then the
// terms are added to the previous drive and clamped into the result register.
// Throughput is one sample per cycle unless the receiver stalls; the feedback of
// the previous drive into the clamp and of the integrator into its own add is combinational.
// Reset clears the terms, the integrator, the stored error and the stored
// drive, sets gains and target to zero and opens the integrator limits fully.
// When the receiver stalls with a result pending, the whole pipeline holds and
// meas.ready drops; when the result register is free, samples keep flowing.
// Configuration writes via cfg_we/cfg_idx/cfg_wdata take effect at once and
// are meant to be issued while no sample is in flight.
// ----------------------------------------------------------------------------
module pid_speed_pwm_controller_core (
	input  logic                             clk,
	input  logic                             arst_n,
	psc_stream_if.sink                       meas,
	psc_stream_if.source                     drive,
	input  logic                             cfg_we,
	input  logic [psc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [psc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import psc_pkg::*;

	cfg_t   cfg_q;
	terms_t terms;
	logic   adv;
	logic   take;
	logic   valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_speed <= '0;
			cfg_q.gain_p       <= '0;
			cfg_q.gain_i       <= '0;
			cfg_q.gain_d       <= '0;
			cfg_q.integ_upper  <= {1'b0, {(LIMIT_W-1){1'b1}}};
			cfg_q.integ_lower  <= {1'b1, {(LIMIT_W-1){1'b0}}};
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_TARGET:      cfg_q.target_speed <= cfg_wdata[SPEED_W-1:0];
				REG_GAIN_P:      cfg_q.gain_p       <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_I:      cfg_q.gain_i       <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_D:      cfg_q.gain_d       <= cfg_wdata[GAIN_W-1:0];
				REG_INTEG_UPPER: cfg_q.integ_upper  <= cfg_wdata[LIMIT_W-1:0];
				REG_INTEG_LOWER: cfg_q.integ_lower  <= cfg_wdata[LIMIT_W-1:0];
				default: begin
					// Writes to unused indexes are dropped.
				end
			endcase
		end
	end

	assign meas.ready = adv;
	assign take       = meas.valid && adv;

	psc_terms u_terms (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.adv       (adv),
		.take      (take),
		.meas_data (meas.payload),
		.valid_s2  (valid_s2),
		.terms     (terms)
	);

	psc_drive u_drive (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.terms    (terms),
		.adv      (adv),
		.drive    (drive)
	);

endmodule

// ===== dv/pwm_drive_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM drive monitor for the PID speed controller
// Follows register writes and accepted speed samples, predicts each drive
// value, and compares the drive channel against the predictions in order.
// ----------------------------------------------------------------------------
module pwm_drive_monitor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           meas_valid,
	input  logic                           meas_ready,
	input  psc_pkg::meas_t                 meas_payload,
	input  logic                           drive_valid,
	input  logic                           drive_ready,
	input  psc_pkg::drive_t                drive_payload,
	input  logic                           cfg_we,
	input  logic [psc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [psc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                             fail_count,
	output int                             pending,
	output int                             checked
);
	import psc_pkg::*;

	// Register copies.
	logic signed [SPEED_W-1:0] target;
	logic signed [GAIN_W-1:0]  kp;
	logic signed [GAIN_W-1:0]  ki;
	logic signed [GAIN_W-1:0]  kd;
	logic signed [LIMIT_W-1:0] lim_hi;
	logic signed [LIMIT_W-1:0] lim_lo;

	// Controller state.
	logic signed [ERR_W-1:0] last_err;
	logic signed [TI_W-1:0]  integ;
	logic signed [TP_W-1:0]  p_term;
	logic signed [TI_W-1:0]  i_term;
	logic signed [TD_W-1:0]  d_term;
	logic [DRIVE_W-1:0]      last_drive;

	logic [DRIVE_W-1:0] expected_drives[$];
	logic [DRIVE_W-1:0] want;

	function automatic logic [DRIVE_W-1:0] next_drive(input meas_t s);
		longint err;
		longint acc;
		longint sum;
		longint whole;
		if (s.measured_valid) begin
			err = longint'($signed(target)) - longint'($signed(s.measured_speed));
			p_term = TP_W'(longint'($signed(kp)) * err);
			acc = longint'($signed(integ)) + longint'($signed(ki)) * err;
			// Upper limit first, so the lower one wins when the limits cross.
			if (acc > longint'($signed(lim_hi)))
				acc = longint'($signed(lim_hi));
			if (acc < longint'($signed(lim_lo)))
				acc = longint'($signed(lim_lo));
			integ = TI_W'(acc);
			i_term = TI_W'(acc);
			d_term = TD_W'(longint'($signed(kd)) * (longint'($signed(last_err)) - err));
			last_err = ERR_W'(err);
		end
		sum = longint'(last_drive) * 256 + longint'($signed(p_term))
			+ longint'($signed(i_term)) + longint'($signed(d_term));
		// Integer division truncates toward zero, as the block does.
		whole = sum / 256;
		if (whole > longint'(DRIVE_MAX))
			whole = longint'(DRIVE_MAX);
		if (whole < longint'(DRIVE_MIN))
			whole = longint'(DRIVE_MIN);
		last_drive = DRIVE_W'(whole);
		return last_drive;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target = '0;
			kp = '0;
			ki = '0;
			kd = '0;
			lim_hi = 32'h7FFF_FFFF;
			lim_lo = 32'h8000_0000;
			last_err = '0;
			integ = '0;
			p_term = '0;
			i_term = '0;
			d_term = '0;
			last_drive = '0;
			expected_drives.delete();
			fail_count = 0;
			checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_TARGET:      target = cfg_wdata[SPEED_W-1:0];
					REG_GAIN_P:      kp = cfg_wdata[GAIN_W-1:0];
					REG_GAIN_I:      ki = cfg_wdata[GAIN_W-1:0];
					REG_GAIN_D:      kd = cfg_wdata[GAIN_W-1:0];
					REG_INTEG_UPPER: lim_hi = cfg_wdata;
					REG_INTEG_LOWER: lim_lo = cfg_wdata;
					default: ;
				endcase
			end
			if (drive_valid && drive_ready) begin
				if (expected_drives.size() == 0) begin
					$error("pwm_drive: unexpected request carrying %0d",
						drive_payload.pwm_drive);
					fail_count++;
				end else begin
					want = expected_drives.pop_front();
					checked++;
					if (drive_payload.pwm_drive !== want) begin
						$error("pwm_drive: expected %0d, actual %0d", want,
							drive_payload.pwm_drive);
						fail_count++;
					end
				end
			end
			if (meas_valid && meas_ready)
				expected_drives.push_back(next_drive(meas_payload));
		end
		pending = expected_drives.size();
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID speed controller testbench
// Drives speed samples and register settings into the controller with random
// gaps and receiver stalls; the drive monitor predicts and checks each value.
// ----------------------------------------------------------------------------
module testbench;
	import psc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 125;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	bit idling = 1'b1;

	int fail_count;
	int pending;
	int checked;
	int sent;
	int invalid_sent;
	int settings_loaded;
	logic [SPEED_W-1:0] cur_target;

	psc_stream_if #(.payload_t(meas_t))  meas_if ();
	psc_stream_if #(.payload_t(drive_t)) drive_if ();

	pid_speed_pwm_controller_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.meas      (meas_if),
		.drive     (drive_if),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	pwm_drive_monitor drive_mon (
		.clk           (clk),
		.arst_n        (arst_n),
		.meas_valid    (meas_if.valid),
		.meas_ready    (meas_if.ready),
		.meas_payload  (meas_if.payload),
		.drive_valid   (drive_if.valid),
		.drive_ready   (drive_if.ready),
		.drive_payload (drive_if.payload),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("pid_speed_pwm_controller_core verification failed");
		$finish;
	end

	// Receiver side: random stalls unless the quiet stretch is running.
	initial begin
		drive_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			drive_if.ready <= idling ? ($urandom_range(99) >= 30) : 1'b1;
		end
	end

	// All tasks start and end just after a falling edge.
	task automatic send_sample(input logic [SPEED_W-1:0] spd, input logic ok);
		while (idling && $urandom_range(99) < 30) begin
			meas_if.valid <= 1'b0;
			@(negedge clk);
		end
		meas_if.valid <= 1'b1;
		meas_if.payload <= {spd, ok};
		@(posedge clk);
		while (!meas_if.ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
		if (!ok)
			invalid_sent++;
	endtask

	// Stop sending and wait for every predicted drive value to come back.
	task automatic drain_drives();
		meas_if.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(negedge clk);
	endtask

	task automatic load_settings(input logic [SPEED_W-1:0] tgt, input logic [GAIN_W-1:0] gp,
			input logic [GAIN_W-1:0] gi, input logic [GAIN_W-1:0] gd,
			input logic [LIMIT_W-1:0] hi, input logic [LIMIT_W-1:0] lo);
		write_reg(REG_TARGET, {16'h0000, tgt});
		write_reg(REG_GAIN_P, {16'h0000, gp});
		write_reg(REG_GAIN_I, {16'h0000, gi});
		write_reg(REG_GAIN_D, {16'h0000, gd});
		write_reg(REG_INTEG_UPPER, hi);
		write_reg(REG_INTEG_LOWER, lo);
		cfg_we <= 1'b0;
		@(negedge clk);
		cur_target = tgt;
		settings_loaded++;
	endtask

	function automatic logic [GAIN_W-1:0] rand_gain();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2, 3: return 16'($urandom);
			default: return 16'($urandom_range(0, 511) - 256);
		endcase
	endfunction

	initial begin
		logic [SPEED_W-1:0] tgt;
		logic [SPEED_W-1:0] spd;
		logic [LIMIT_W-1:0] hi;
		logic [LIMIT_W-1:0] lo;
		logic [LIMIT_W-1:0] m;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		meas_if.valid = 1'b0;
		meas_if.payload = '0;
		cur_target = '0;
		sent = 0;
		invalid_sent = 0;
		settings_loaded = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: zero gains, so the drive sits at its floor.
		send_sample(16'h0000, 1'b1);
		send_sample(16'h7FFF, 1'b1);
		send_sample(16'h1234, 1'b0);
		drain_drives();

		// Writes to unused indexes must change nothing.
		write_reg(REG_SPARE_6, $urandom);
		write_reg(REG_SPARE_7, $urandom);
		load_settings(16'd1000, 16'h0040, 16'h0008, 16'h0020, 32'd51200, 32'hFFFF_3800);
		send_sample(16'h0000, 1'b1);
		send_sample(16'h7FFF, 1'b1);
		send_sample(16'h8000, 1'b1);
		send_sample(16'd1000, 1'b1);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'd900, 1'b1);
		send_sample(16'd1100, 1'b1);
		drain_drives();

		// Extreme gains with the integrator limits fully open.
		load_settings(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_sample(16'h7FFF, 1'b1);
		send_sample(16'h8000, 1'b1);
		send_sample(16'h0000, 1'b1);
		send_sample(16'h7FFF, 1'b0);
		drain_drives();

		// Crossed limits: the lower one has to win.
		load_settings(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 32'hFFFF_FC18, 32'd5000);
		send_sample(16'h8000, 1'b1);
		send_sample(16'h7FFF, 1'b1);
		send_sample(16'h0005, 1'b1);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7000, 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_drives();
			tgt = ($urandom_range(3) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 4000) - 2000);
			m = $urandom_range(0, 32'h0040_0000);
			case ($urandom_range(5))
				0: begin
					hi = 32'h7FFF_FFFF;
					lo = 32'h8000_0000;
				end
				1: begin
					hi = -m;
					lo = m;
				end
				2: begin
					hi = $urandom;
					lo = $urandom;
				end
				default: begin
					hi = m;
					lo = -m;
				end
			endcase
			load_settings(tgt, rand_gain(), rand_gain(), rand_gain(), hi, lo);
			// One phase runs with neither side idling.
			idling = (ph != 5);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 8 && n == PHASE_ITEMS / 2)
					drain_drives();
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5:
						spd = cur_target + 16'($urandom_range(0, 600)) - 16'd300;
					6, 7, 8: spd = 16'($urandom);
					default: begin
						case ($urandom_range(2))
							0: spd = 16'h8000;
							1: spd = 16'h7FFF;
							default: spd = 16'h0000;
						endcase
					end
				endcase
				send_sample(spd, $urandom_range(99) >= 12);
			end
		end
		idling = 1'b1;
		drain_drives();
		repeat (8) @(negedge clk);

		$display("Summary: %0d speed samples (%0d flagged unusable) under %0d register settings,",
			sent, invalid_sent, settings_loaded);
		$display("         %0d drive values compared, with random gaps and stalls.", checked);
		if (fail_count == 0 && pending == 0)
			$display("pid_speed_pwm_controller_core verification clean");
		else
			$display("pid_speed_pwm_controller_core verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/psc_pkg.sv
rtl/psc_stream_if.sv
rtl/psc_terms.sv
rtl/psc_drive.sv
rtl/pid_speed_pwm_controller_core.sv
dv/pwm_drive_monitor.sv
dv/testbench.sv
